// File: hw/rtl/bthin_pkg.sv
// Shared types, codes and the Zhang-Suen deletion test for the binary image thinning block.
// Depends on nothing; bthin_scan and the top level refer to it by scoped names, the checker and testbench import it.
`default_nettype none

package bthin_pkg;

  // Command opcodes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd1;

  // Reset value of both size registers.
  localparam logic [8:0] SIZE_RESET = 9'd256;

  // Neighbor count window of the deletion test and the iteration ceiling.
  localparam logic [3:0] ZS_MIN_NEIGHBORS = 4'd2;
  localparam logic [3:0] ZS_MAX_NEIGHBORS = 4'd6;
  localparam logic [7:0] ITER_MAX         = 8'd255;

  // Channel payloads.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] row;
    logic [7:0] column;
    logic       pixel_in;
  } cmd_item_t;

  typedef struct packed {
    logic       pixel_out;
    logic [7:0] iterations;
  } rsp_item_t;

  typedef struct packed {
    logic [3:0] index;
    logic [8:0] value;
  } cfg_write_t;

  // Run sequencer in the top level.
  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_PASS0,
    RUN_PASS1,
    RUN_FINISH
  } run_state_t;

  // Subpass scanner.
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_ISSUE,
    SC_DRAIN
  } scan_state_t;

  // Control from the run sequencer to the scanner.
  typedef struct packed {
    logic start;
    logic pass;
  } scan_ctrl_t;

  // Status from the scanner back to the run sequencer.
  typedef struct packed {
    logic done;
    logic removed;
  } scan_stat_t;

  // Deletion test for a foreground pixel. nb[0] is the north neighbor, then clockwise.
  // second selects the rule of the second subpass.
  function automatic logic zs_delete(input logic [7:0] nb, input logic second);
    logic [3:0] cnt;
    logic [3:0] trans;
    logic       cond;
    cnt   = 4'd0;
    trans = 4'd0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + {3'd0, nb[k]};
      if (!nb[k] && nb[3'(k + 1)]) begin
        trans = trans + 4'd1;
      end
    end
    if (second) begin
      cond = !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
    end else begin
      cond = !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
    end
    return (cnt >= ZS_MIN_NEIGHBORS) && (cnt <= ZS_MAX_NEIGHBORS) && (trans == 4'd1) && cond;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bthin_chan_if.sv
// Valid/ready channel interface used for the command, response and configuration channels.
// The payload type is a parameter; the payload structs come from bthin_pkg.
`default_nettype none

interface bthin_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bthin_scan.sv
// One Zhang-Suen subpass over the pixel store: raster scan, line buffer memory and 3x3 window.
// Depends on bthin_pkg; the pixel store itself lives in the top level and is reached by ports.
`default_nettype none

module bthin_scan #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire bthin_pkg::scan_ctrl_t                           ctrl,
  output      bthin_pkg::scan_stat_t                           stat,
  input  wire logic [$clog2(MAX_WIDTH + 1)-1:0]                w_eff,
  input  wire logic [$clog2(MAX_HEIGHT + 1)-1:0]               h_eff,
  output      logic                                            mem_re,
  output      logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] mem_raddr,
  input  wire logic                                            mem_rdata,
  output      logic                                            mem_we,
  output      logic [$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] mem_waddr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  bthin_pkg::scan_state_t state, state_next;

  // Scan position: x is the column being fetched, rd_row the row fetched from the store.
  // The window center trails one column and one row behind.
  logic          pass;
  logic [XW-1:0] x;
  logic [YW-1:0] rd_row;
  logic          any;

  // Fetch stage (data returns from both memories).
  logic          b_valid;
  logic [XW-1:0] b_x;
  logic [YW-1:0] b_rd_row;
  logic          b_main_ok;
  logic          b_lb_ok;
  logic          b_lb_wr;

  // Decision stage.
  logic          c_valid;
  logic [XW-1:0] c_x;
  logic [YW-1:0] c_rd_row;

  // Window columns: bit 2 is the row above the center, bit 0 the row below.
  logic [2:0]    col_l, col_m, col_r;

  // Line buffer: per column, bit 1 holds the row above the center, bit 0 the center row.
  logic [1:0]    lbuf [0:MAX_WIDTH-1];
  logic [1:0]    lb_rdata;

  logic          issue;
  logic          x_in;
  logic          row_in;
  logic          lb_re;
  logic          main_bit;
  logic [1:0]    lb_eff;
  logic [7:0]    nb;
  logic          del;
  logic [YW-1:0] center_row;
  logic [XW-1:0] center_col;

  // Fetch addressing.
  assign issue     = (state == bthin_pkg::SC_ISSUE);
  assign x_in      = (x < w_eff);
  assign row_in    = (rd_row < h_eff);
  assign mem_re    = issue && x_in && row_in;
  assign mem_raddr = {rd_row[RW-1:0], x[CW-1:0]};
  assign lb_re     = issue && x_in;

  // Returned data, with everything outside the image forced to background.
  assign main_bit = b_main_ok & mem_rdata;
  assign lb_eff   = b_lb_ok ? lb_rdata : 2'b00;

  // Neighbors P2..P9 around the window center.
  assign nb = {col_l[2], col_l[1], col_l[0], col_m[0], col_r[0], col_r[1], col_r[2], col_m[2]};

  // Deletion decision; the store is written in place since the window holds the old values.
  assign center_row = c_rd_row - YW'(1);
  assign center_col = c_x - XW'(1);
  assign del        = c_valid && (c_x != '0) && (c_rd_row != '0) && col_m[1] &&
                      bthin_pkg::zs_delete(nb, pass);
  assign mem_we     = del;
  assign mem_waddr  = {center_row[RW-1:0], center_col[CW-1:0]};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bthin_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, done strobe and removal status.
  always_comb begin
    state_next   = state;
    stat.done    = 1'b0;
    stat.removed = any;
    unique case (state)
      bthin_pkg::SC_IDLE: begin
        state_next = bthin_pkg::SC_IDLE;
      end
      bthin_pkg::SC_ISSUE: begin
        if ((x == w_eff) && (rd_row == h_eff)) begin
          state_next = bthin_pkg::SC_DRAIN;
        end
      end
      bthin_pkg::SC_DRAIN: begin
        if (!b_valid && !c_valid) begin
          stat.done  = 1'b1;
          state_next = bthin_pkg::SC_IDLE;
        end
      end
      default: begin
        state_next = bthin_pkg::SC_IDLE;
      end
    endcase
    if (ctrl.start) begin
      state_next = bthin_pkg::SC_ISSUE;
    end
  end

  // Scan counters, removal flag and pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      pass    <= 1'b0;
      x       <= '0;
      rd_row  <= '0;
      any     <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= issue;
      c_valid <= b_valid;
      if (ctrl.start) begin
        pass   <= ctrl.pass;
        x      <= '0;
        rd_row <= '0;
        any    <= 1'b0;
      end else begin
        if (issue) begin
          if (x == w_eff) begin
            x      <= '0;
            rd_row <= rd_row + YW'(1);
          end else begin
            x <= x + XW'(1);
          end
        end
        if (del) begin
          any <= 1'b1;
        end
      end
    end
  end

  // Pipeline payload and window shift.
  always_ff @(posedge clk) begin
    b_x       <= x;
    b_rd_row  <= rd_row;
    b_main_ok <= x_in && row_in;
    b_lb_ok   <= x_in && (rd_row != '0);
    b_lb_wr   <= x_in;
    c_x       <= b_x;
    c_rd_row  <= b_rd_row;
    if (b_valid) begin
      if (b_x == '0) begin
        col_l <= 3'b000;
        col_m <= 3'b000;
      end else begin
        col_l <= col_m;
        col_m <= col_r;
      end
      col_r <= {lb_eff[1], lb_eff[0], main_bit};
    end
  end

  // Line buffer memory: read at the fetch column, rolled down one row on return.
  always_ff @(posedge clk) begin
    if (lb_re) begin
      lb_rdata <= lbuf[x[CW-1:0]];
    end
    if (b_valid && b_lb_wr) begin
      lbuf[b_x[CW-1:0]] <= {lb_eff[0], main_bit};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/binary_image_thinning.sv
// Top level of the binary image thinning block: pixel store, command handling, run sequencer.
// Depends on bthin_pkg, bthin_chan_if and bthin_scan.
//
// Use: pixels are loaded through the cmd channel (opcode write) one transfer per cycle
// and read back (opcode read) one per cycle, both while rsp is not stalled, and thinned in
// place by a run command. Every command gives exactly one transfer on rsp: pixel_out is the
// stored pixel for a read and zero otherwise; iterations is the iteration count of the last
// run. The cfg channel sets image_width and image_height (always ready); the user must see that
// it is written only while the block is idle; the block itself does not enforce this. A write or
// read result passes through the result stage and the response register. A run scans the
// image once per subpass through the single read port of the store, one pixel per cycle; an
// iteration is two subpasses, and the run repeats iterations until one removes nothing. Its
// result passes the finish state, the result stage and the response register, held back
// while rsp stalls. No command enters during a run.
// Reset: control state clears, both size registers return to 256 and the iteration count
// to zero; the pixel store is not cleared and holds no defined value until written.
// Stall: while rsp is stalled the result is held and one more command may still enter.
`default_nettype none

module binary_image_thinning #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input wire logic    clk,
  input wire logic    rst,
  bthin_chan_if.sink   cmd,
  bthin_chan_if.source rsp,
  bthin_chan_if.sink   cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = RW + CW;

  bthin_pkg::run_state_t run_state, run_state_next;
  bthin_pkg::scan_ctrl_t scan_ctrl;
  bthin_pkg::scan_stat_t scan_stat;

  logic [8:0]    image_width;
  logic [8:0]    image_height;
  logic [7:0]    iteration_count;
  logic          any0;

  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;

  // Pixel store, one read and one write port.
  logic          store [0:(1 << AW)-1];
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic          st_rdata;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic          st_wdata;

  logic          sc_re;
  logic [AW-1:0] sc_raddr;
  logic          sc_we;
  logic [AW-1:0] sc_waddr;

  // Result stage ahead of the response register.
  logic          p_valid;
  logic          p_read;

  logic          idle;
  logic          out_free;
  logic          acc;
  logic          addr_ok;
  logic [AW-1:0] item_addr;
  logic          finish_load;
  logic          changed;

  // Effective image size, clamped to the store.
  always_comb begin
    if (32'(image_width) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(image_width);
    end
    if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(image_height);
    end
  end

  // Command transfer.
  assign idle      = (run_state == bthin_pkg::RUN_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = idle && (!p_valid || out_free);
  assign acc       = cmd.valid && cmd.ready;
  assign addr_ok   = (32'(cmd.data.row) < MAX_HEIGHT) && (32'(cmd.data.column) < MAX_WIDTH);
  assign item_addr = {RW'(cmd.data.row), CW'(cmd.data.column)};

  assign cfg.ready = 1'b1;

  // Store port selection: commands while idle, the scanner during a run.
  assign st_re    = idle ? (acc && (cmd.data.opcode == bthin_pkg::OP_READ)) : sc_re;
  assign st_raddr = idle ? item_addr : sc_raddr;
  assign st_we    = idle ? (acc && (cmd.data.opcode == bthin_pkg::OP_WRITE) && addr_ok) : sc_we;
  assign st_waddr = idle ? item_addr : sc_waddr;
  assign st_wdata = idle ? cmd.data.pixel_in : 1'b0;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata <= store[st_raddr];
    end
  end

  bthin_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .stat      (scan_stat),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .mem_re    (sc_re),
    .mem_raddr (sc_raddr),
    .mem_rdata (st_rdata),
    .mem_we    (sc_we),
    .mem_waddr (sc_waddr)
  );

  // Run sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= bthin_pkg::RUN_IDLE;
    end else begin
      run_state <= run_state_next;
    end
  end

  // Run sequencer: two subpasses per iteration until an iteration removes nothing.
  assign changed = any0 || scan_stat.removed;

  always_comb begin
    run_state_next  = run_state;
    scan_ctrl.start = 1'b0;
    scan_ctrl.pass  = 1'b0;
    finish_load     = 1'b0;
    unique case (run_state)
      bthin_pkg::RUN_IDLE: begin
        if (acc && (cmd.data.opcode == bthin_pkg::OP_RUN)) begin
          scan_ctrl.start = 1'b1;
          run_state_next  = bthin_pkg::RUN_PASS0;
        end
      end
      bthin_pkg::RUN_PASS0: begin
        if (scan_stat.done) begin
          scan_ctrl.start = 1'b1;
          scan_ctrl.pass  = 1'b1;
          run_state_next  = bthin_pkg::RUN_PASS1;
        end
      end
      bthin_pkg::RUN_PASS1: begin
        if (scan_stat.done) begin
          if (changed) begin
            scan_ctrl.start = 1'b1;
            run_state_next  = bthin_pkg::RUN_PASS0;
          end else begin
            run_state_next = bthin_pkg::RUN_FINISH;
          end
        end
      end
      bthin_pkg::RUN_FINISH: begin
        if (!p_valid) begin
          finish_load    = 1'b1;
          run_state_next = bthin_pkg::RUN_IDLE;
        end
      end
      default: begin
        run_state_next = bthin_pkg::RUN_IDLE;
      end
    endcase
  end

  // Configuration registers, iteration count and first-subpass removal flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= bthin_pkg::SIZE_RESET;
      image_height    <= bthin_pkg::SIZE_RESET;
      iteration_count <= 8'd0;
      any0            <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.data.index)
          bthin_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data.value;
          bthin_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data.value;
          default: ;
        endcase
      end
      if (idle && acc && (cmd.data.opcode == bthin_pkg::OP_RUN)) begin
        iteration_count <= 8'd0;
      end
      if ((run_state == bthin_pkg::RUN_PASS0) && scan_stat.done) begin
        any0 <= scan_stat.removed;
      end
      if ((run_state == bthin_pkg::RUN_PASS1) && scan_stat.done &&
          (iteration_count != bthin_pkg::ITER_MAX)) begin
        iteration_count <= iteration_count + 8'd1;
      end
    end
  end

  // Result stage and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if ((acc && (cmd.data.opcode != bthin_pkg::OP_RUN)) || finish_load) begin
        p_valid <= 1'b1;
      end else if (out_free) begin
        p_valid <= 1'b0;
      end
      if (p_valid && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_read <= (cmd.data.opcode == bthin_pkg::OP_READ) && addr_ok;
    end else if (finish_load) begin
      p_read <= 1'b0;
    end
    if (p_valid && out_free) begin
      rsp.data.pixel_out  <= p_read & st_rdata;
      rsp.data.iterations <= iteration_count;
    end
  end

endmodule

`default_nettype wire

// File: dv/binary_image_thinning_checker.sv
// Checker for the binary image thinning block: keeps its own copy of the size registers,
// the pixel store and the iteration count, predicts one result per command, and compares
// results in order. Depends on bthin_pkg and the bthin_chan_if channel interface.
module binary_image_thinning_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  bthin_chan_if       cmd,
  bthin_chan_if       rsp,
  bthin_chan_if       cfg,
  output int unsigned fail_count,
  output int unsigned pending
);
  import bthin_pkg::*;

  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [7:0]  iter_count;
  bit          mask [MAX_WIDTH*MAX_HEIGHT];
  rsp_item_t   expected_q [$];
  int unsigned result_num;

  // Foreground test with everything outside the active image reading as background.
  function automatic bit fg(input int r, input int c, input int h, input int w);
    if (r < 0 || c < 0 || r >= h || c >= w) begin
      return 1'b0;
    end
    return mask[r*MAX_WIDTH + c];
  endfunction

  // One subpass: judge every pixel on the image as it stood at the start, then clear.
  function automatic bit thin_subpass(input bit second, input int h, input int w);
    bit [7:0] nb;
    int       flips;
    bit       rule_ok;
    int       doomed [$];
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (fg(r, c, h, w)) begin
          // Bit 0 is north, then clockwise.
          nb = {fg(r-1, c-1, h, w), fg(r, c-1, h, w), fg(r+1, c-1, h, w), fg(r+1, c, h, w),
                fg(r+1, c+1, h, w), fg(r, c+1, h, w), fg(r-1, c+1, h, w), fg(r-1, c, h, w)};
          flips = 0;
          for (int k = 0; k < 8; k++) begin
            if (!nb[k] && nb[(k+1)%8]) begin
              flips++;
            end
          end
          if (second) begin
            rule_ok = !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
          end else begin
            rule_ok = !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
          end
          if ($countones(nb) >= 2 && $countones(nb) <= 6 && flips == 1 && rule_ok) begin
            doomed.insert(doomed.size(), r*MAX_WIDTH + c);
          end
        end
      end
    end
    foreach (doomed[i]) begin
      mask[doomed[i]] = 1'b0;
    end
    return doomed.size() != 0;
  endfunction

  // Full thinning run; returns the saturating iteration count.
  function automatic logic [7:0] thin_image();
    int         w;
    int         h;
    bit         first_hit;
    bit         second_hit;
    logic [7:0] n;
    w = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    n = '0;
    do begin
      first_hit  = thin_subpass(1'b0, h, w);
      second_hit = thin_subpass(1'b1, h, w);
      if (n < ITER_MAX) begin
        n = n + 8'd1;
      end
    end while (first_hit || second_hit);
    return n;
  endfunction

  // Sample at the falling edge: the values seen here are the ones the next rising edge uses.
  always @(negedge clk) begin
    rsp_item_t want_new;
    rsp_item_t want;
    int        addr;
    bit        in_store;
    if (rst) begin
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      iter_count = '0;
      expected_q.delete();
      fail_count = 0;
      result_num = 0;
    end else begin
      // Register writes.
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          REG_IMAGE_WIDTH:  width_reg  = cfg.data.value;
          REG_IMAGE_HEIGHT: height_reg = cfg.data.value;
          default: ;
        endcase
      end

      // Command transfer: update the store and queue the result it causes.
      if (cmd.valid && cmd.ready) begin
        addr     = int'(cmd.data.row)*MAX_WIDTH + int'(cmd.data.column);
        in_store = int'(cmd.data.row) < MAX_HEIGHT && int'(cmd.data.column) < MAX_WIDTH;
        want_new.pixel_out = 1'b0;
        case (cmd.data.opcode)
          OP_WRITE: begin
            if (in_store) begin
              mask[addr] = cmd.data.pixel_in;
            end
          end
          OP_RUN: iter_count = thin_image();
          OP_READ: begin
            if (in_store) begin
              want_new.pixel_out = mask[addr];
            end
          end
          default: ;
        endcase
        want_new.iterations = iter_count;
        expected_q.insert(expected_q.size(), want_new);
      end

      // Result transfer: compare against the oldest expectation.
      if (rsp.valid && rsp.ready) begin
        result_num++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d arrived with no command waiting: pixel_out=%0b iterations=%0d",
                     result_num, rsp.data.pixel_out, rsp.data.iterations);
          end
        end else begin
          want = expected_q.pop_front();
          if (rsp.data.pixel_out !== want.pixel_out || rsp.data.iterations !== want.iterations)
          begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch: expected pixel_out=%0b iterations=%0d, got %0b %0d",
                       result_num, want.pixel_out, want.iterations,
                       rsp.data.pixel_out, rsp.data.iterations);
            end
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// File: dv/binary_image_thinning_tb.sv
// Testbench top for the binary image thinning block: clock, reset, command and register
// stimulus, result back-pressure and the verdict. Depends on bthin_pkg, bthin_chan_if,
// binary_image_thinning and binary_image_thinning_checker.
module binary_image_thinning_tb;
  import bthin_pkg::*;

  localparam int         MAX_WIDTH   = 256;
  localparam int         MAX_HEIGHT  = 256;
  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  bit          calm;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          written [MAX_WIDTH*MAX_HEIGHT];
  int unsigned written_list [$];
  int unsigned n_writes;
  int unsigned n_reads;
  int unsigned n_runs;
  int unsigned n_nops;
  int unsigned n_sizes;

  bthin_chan_if #(.payload_t(cmd_item_t))  cmd_ch ();
  bthin_chan_if #(.payload_t(rsp_item_t))  rsp_ch ();
  bthin_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  binary_image_thinning #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  binary_image_thinning_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg       (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("binary_image_thinning_tb NOT OK");
      $finish;
    end
  end

  // Result back-pressure in random bursts while calm is clear.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(4) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // One command transfer; valid stays high afterward so back-to-back commands need no gap.
  task automatic send_cmd(input logic [1:0] op, input int r, input int c, input bit v);
    cmd_item_t   item;
    bit          ok;
    int unsigned addr;
    if (!calm && $urandom_range(4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item.opcode   = op;
    item.row      = 8'(r);
    item.column   = 8'(c);
    item.pixel_in = v;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    do begin
      @(negedge clk);
      ok = cmd_ch.ready;
      @(posedge clk);
    end while (!ok);
    case (op)
      OP_WRITE: begin
        n_writes++;
        addr = r*MAX_WIDTH + c;
        if (!written[addr]) begin
          written[addr] = 1'b1;
          written_list.insert(written_list.size(), addr);
        end
      end
      OP_RUN:  n_runs++;
      OP_READ: n_reads++;
      default: n_nops++;
    endcase
  endtask

  // Read back a pixel that is known to have been written.
  task automatic read_known();
    int unsigned a;
    a = written_list[$urandom_range(written_list.size() - 1)];
    send_cmd(OP_READ, a / MAX_WIDTH, a % MAX_WIDTH, 1'($urandom_range(1)));
  endtask

  // Stop sending and wait until every queued result has been delivered.
  task automatic drain(input int extra);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_transfer(input logic [3:0] idx, input logic [8:0] value);
    cfg_write_t wr;
    bit         ok;
    wr.index = idx;
    wr.value = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= wr;
    do begin
      @(negedge clk);
      ok = cfg_ch.ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Program the image size once the block has gone idle.
  task automatic set_size(input logic [8:0] w, input logic [8:0] h);
    drain(4);
    cfg_transfer(REG_IMAGE_WIDTH, w);
    cfg_transfer(REG_IMAGE_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
    n_sizes++;
  endtask

  // Stimulus and verdict.
  initial begin
    int p;
    int w;
    int h;
    int ew;
    int eh;
    int mode;
    int density;
    int r0;
    int r1;
    int c0;
    int c1;
    bit v;
    rst          = 1'b1;
    calm         = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no-op before any run, corner addresses, an empty image, a solid 3x3 block.
    send_cmd(OP_NOP, 255, 255, 1'b1);
    set_size(9'd0, 9'd0);
    send_cmd(OP_WRITE, 0, 0, 1'b1);
    send_cmd(OP_WRITE, 255, 255, 1'b1);
    send_cmd(OP_WRITE, 0, 255, 1'b0);
    send_cmd(OP_WRITE, 255, 0, 1'b1);
    send_cmd(OP_READ, 0, 0, 1'b0);
    send_cmd(OP_READ, 255, 255, 1'b1);
    send_cmd(OP_READ, 0, 255, 1'b1);
    send_cmd(OP_READ, 255, 0, 1'b0);
    send_cmd(OP_RUN, 0, 0, 1'b0);
    send_cmd(OP_READ, 0, 0, 1'b0);
    send_cmd(OP_NOP, 0, 0, 1'b0);
    set_size(9'd3, 9'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_cmd(OP_WRITE, r, c, 1'b1);
      end
    end
    send_cmd(OP_RUN, 255, 255, 1'b1);
    send_cmd(OP_READ, 1, 1, 1'b0);
    send_cmd(OP_READ, 0, 0, 1'b1);
    send_cmd(OP_NOP, 255, 255, 1'b1);

    // Random phases: set a size, load the whole image, thin it, read back.
    for (p = 0; p < 7 || n_writes + n_reads + n_runs < 750; p++) begin
      calm = (p >= 5);
      case (p)
        1: begin w = 511; h = 1;   end
        3: begin w = 0;   h = 256; end
        4: begin w = 1;   h = 511; end
        6: begin w = 256; h = 0;   end
        default: begin
          w = $urandom_range(1, ($urandom_range(5) == 0) ? 16 : 9);
          h = $urandom_range(1, ($urandom_range(5) == 0) ? 16 : 9);
        end
      endcase
      set_size(9'(w), 9'(h));
      ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;

      // Pattern: random density, a thick rectangle with speckle, or solid foreground.
      mode    = $urandom_range(2);
      density = $urandom_range(100);
      r0      = $urandom_range(eh / 2);
      r1      = r0 + $urandom_range(eh);
      c0      = $urandom_range(ew / 2);
      c1      = c0 + $urandom_range(ew);

      for (int r = 0; r < eh; r++) begin
        for (int c = 0; c < ew; c++) begin
          // Occasional noise between loads.
          if ($urandom_range(11) == 0) begin
            case ($urandom_range(2))
              0: send_cmd(OP_NOP, $urandom_range(255), $urandom_range(255),
                          1'($urandom_range(1)));
              1: read_known();
              default: send_cmd(OP_WRITE, $urandom_range(255), $urandom_range(255),
                                1'($urandom_range(1)));
            endcase
          end
          case (mode)
            0: v = ($urandom_range(99) < density);
            1: v = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^ ($urandom_range(15) == 0);
            default: v = 1'b1;
          endcase
          send_cmd(OP_WRITE, r, c, v);
        end
      end

      // In the first phase and at random otherwise, hold the run until the block has delivered everything so far.
      if (p == 0 || $urandom_range(1) == 0) begin
        drain(0);
      end
      send_cmd(OP_RUN, $urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));

      // Skeleton readback: whole image when small, a sample otherwise.
      if (ew * eh <= 100) begin
        for (int r = 0; r < eh; r++) begin
          for (int c = 0; c < ew; c++) begin
            send_cmd(OP_READ, r, c, 1'($urandom_range(1)));
          end
        end
      end else begin
        repeat (16) begin
          send_cmd(OP_READ, $urandom_range(eh - 1), $urandom_range(ew - 1),
                   1'($urandom_range(1)));
        end
      end
      repeat (3) read_known();

      // A second run on a thinned image should stop after one iteration.
      if ($urandom_range(3) == 0) begin
        send_cmd(OP_RUN, 0, 0, 1'b0);
        send_cmd(OP_NOP, $urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
        read_known();
      end
    end

    drain(16);
    $display("Covered %0d writes, %0d reads, %0d runs and %0d no-ops over %0d image sizes,",
             n_writes, n_reads, n_runs, n_nops, n_sizes);
    $display("including empty, single-line and oversized images; %0d failures.", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("binary_image_thinning_tb OK");
    end else begin
      $display("binary_image_thinning_tb NOT OK");
    end
    $finish;
  end

endmodule
